FILE: rtl/core/ssem_pkg.sv
package ssem_pkg;

   localparam int STORE_LINES = 32;
   localparam int WORD_W      = 32;

   // Request beat layout.
   localparam int FUNC_W     = 2;
   localparam int LINE_W     = 5;
   localparam int REQ_DATA_W = 40;
   localparam int REQ_PAD_W  = REQ_DATA_W - LINE_W - WORD_W;

   // Response beat layout.
   localparam int RSP_DATA_W = 136;
   localparam int RSP_PAD_W  = RSP_DATA_W - 4 * WORD_W - 1;

   // Request selector codes.
   localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   // Instruction fields.
   localparam int OPC_LSB = 13;
   localparam int OPC_W   = 3;

   localparam logic [OPC_W-1:0] OPC_JMP   = 3'd0;
   localparam logic [OPC_W-1:0] OPC_JRP   = 3'd1;
   localparam logic [OPC_W-1:0] OPC_LDN   = 3'd2;
   localparam logic [OPC_W-1:0] OPC_STO   = 3'd3;
   localparam logic [OPC_W-1:0] OPC_SUB_A = 3'd4;
   localparam logic [OPC_W-1:0] OPC_SUB_B = 3'd5;
   localparam logic [OPC_W-1:0] OPC_CMP   = 3'd6;
   localparam logic [OPC_W-1:0] OPC_STP   = 3'd7;

endpackage

FILE: rtl/core/ssem_ram.sv
module ssem_ram #(
   parameter int WIDTH = ssem_pkg::WORD_W,
   parameter int DEPTH = ssem_pkg::STORE_LINES
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/ssem_stored_program_core_unit.sv
// Small stored-program core with a 32-line store, an accumulator, a control
// counter, a present-instruction register and a halt flag.
// The request channel (req_) carries one beat per command: req_tuser selects
// a step, a store write or a store read, and req_tdata holds the line address
// and the word to write. Every request beat yields exactly one response beat
// on the rsp_ channel carrying the read word (zero unless a read), the
// accumulator, the control counter, the present instruction and the halt flag.
// Requests are taken one at a time; req_tready is high only while the
// sequencer is idle. The response is registered in the response state, which
// comes after the last sequencer step: a write or an unused code goes straight
// to it, a read passes one registered store read first, and a step passes a
// fetch read and an operand read, then executes through the single shared
// 32-bit adder. A step while halted goes straight to the response state. These
// steps are set by the store's single read port and its registered read data.
// If the receiver stalls, the response holds in the output register and the
// sequencer waits in its response state until the register is free, so a new
// request may be accepted while the previous response still waits.
// Reset (synchronous, active high) clears the machine registers and the
// response valid flag, and marks every store line as unwritten; unwritten
// lines read as zero, so the store looks cleared at once with no clearing pass.
module ssem_stored_program_core_unit #(
   parameter int STORE_LINES = ssem_pkg::STORE_LINES
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata fields from bit 0: line_address[4:0], write_word[36:5], zero pad.
   input  logic [ssem_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser fields from bit 0: func[1:0].
   input  logic [ssem_pkg::FUNC_W-1:0]         req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rsp_tdata fields from bit 0: read_word[31:0], accumulator_value[63:32],
   // counter_value[95:64], fetched_word[127:96], is_halted[128], zero pad.
   output logic [ssem_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready
);

   localparam int AW = $clog2(STORE_LINES);
   localparam int W  = ssem_pkg::WORD_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_FETCH = 3'd2;
   localparam logic [2:0] S_EXEC  = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [W-1:0]           acc_ff, acc_in;
   logic [W-1:0]           cc_ff, cc_in;
   logic [W-1:0]           pi_ff, pi_in;
   logic                   halt_ff, halt_in;
   logic [W-1:0]           rd_ff, rd_in;
   logic [STORE_LINES-1:0] valid_ff, valid_in;
   logic                   rvalid_ff, rvalid_in;
   logic [ssem_pkg::RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;

   logic [ssem_pkg::FUNC_W-1:0] req_func;
   logic [AW-1:0]          req_line;
   logic [W-1:0]           req_word;
   logic                   req_fire;

   logic                   ram_wr_en, ram_rd_en;
   logic [AW-1:0]          ram_wr_addr, ram_rd_addr;
   logic [W-1:0]           ram_wr_data, ram_rd_data;
   logic [W-1:0]           mem_word;

   logic [W-1:0]           alu_a, alu_b, alu_sum;
   logic                   alu_cin;
   logic [ssem_pkg::OPC_W-1:0] opc;
   logic                   out_free;

   assign req_func = req_tuser;
   assign req_line = req_tdata[AW-1:0];
   assign req_word = req_tdata[ssem_pkg::LINE_W +: W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;

   // Lines never written since reset read as zero.
   assign mem_word = rvalid_ff ? ram_rd_data : '0;
   assign opc = pi_ff[ssem_pkg::OPC_LSB +: ssem_pkg::OPC_W];
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // The one shared adder: increments, relative jumps and subtractions
   // (subtraction as add of the inverted operand with carry in).
   assign alu_sum = alu_a + alu_b + {{(W-1){1'b0}}, alu_cin};

   ssem_ram #(
      .WIDTH(W),
      .DEPTH(STORE_LINES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      cc_in         = cc_ff;
      pi_in         = pi_ff;
      halt_in       = halt_ff;
      rd_in         = rd_ff;
      valid_in      = valid_ff;
      rvalid_in     = rvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = req_line;
      ram_wr_data   = req_word;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = req_line;
      alu_a         = cc_ff;
      alu_b         = '0;
      alu_cin       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rd_in    = '0;
               state_in = S_RESP;
               unique case (req_func)
                  ssem_pkg::FUNC_STEP: begin
                     if (!halt_ff) begin
                        alu_cin     = 1'b1;
                        cc_in       = alu_sum;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = alu_sum[AW-1:0];
                        rvalid_in   = valid_ff[alu_sum[AW-1:0]];
                        state_in    = S_FETCH;
                     end
                  end
                  ssem_pkg::FUNC_WRITE: begin
                     ram_wr_en          = 1'b1;
                     valid_in[req_line] = 1'b1;
                  end
                  ssem_pkg::FUNC_READ: begin
                     ram_rd_en = 1'b1;
                     rvalid_in = valid_ff[req_line];
                     state_in  = S_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            rd_in    = mem_word;
            state_in = S_RESP;
         end
         S_FETCH: begin
            pi_in       = mem_word;
            ram_rd_en   = 1'b1;
            ram_rd_addr = mem_word[AW-1:0];
            rvalid_in   = valid_ff[mem_word[AW-1:0]];
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            unique case (opc) inside
               ssem_pkg::OPC_JMP: begin
                  cc_in = mem_word;
               end
               ssem_pkg::OPC_JRP: begin
                  alu_b = mem_word;
                  cc_in = alu_sum;
               end
               ssem_pkg::OPC_LDN: begin
                  alu_a   = '0;
                  alu_b   = ~mem_word;
                  alu_cin = 1'b1;
                  acc_in  = alu_sum;
               end
               ssem_pkg::OPC_STO: begin
                  ram_wr_en               = 1'b1;
                  ram_wr_addr             = pi_ff[AW-1:0];
                  ram_wr_data             = acc_ff;
                  valid_in[pi_ff[AW-1:0]] = 1'b1;
               end
               ssem_pkg::OPC_SUB_A, ssem_pkg::OPC_SUB_B: begin
                  alu_a   = acc_ff;
                  alu_b   = ~mem_word;
                  alu_cin = 1'b1;
                  acc_in  = alu_sum;
               end
               ssem_pkg::OPC_CMP: begin
                  // Skip the next instruction when the accumulator is negative.
                  alu_cin = acc_ff[W-1];
                  cc_in   = alu_sum;
               end
               default: begin
                  halt_in = 1'b1;
               end
            endcase
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_tdata_in  = {{ssem_pkg::RSP_PAD_W{1'b0}}, halt_ff, pi_ff, cc_ff,
                                acc_ff, rd_ff};
               rsp_tvalid_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         acc_ff        <= '0;
         cc_ff         <= '0;
         pi_ff         <= '0;
         halt_ff       <= 1'b0;
         valid_ff      <= '0;
         rvalid_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         acc_ff        <= acc_in;
         cc_ff         <= cc_in;
         pi_ff         <= pi_in;
         halt_ff       <= halt_in;
         valid_ff      <= valid_in;
         rvalid_ff     <= rvalid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff        <= rd_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

FILE: test/tb_ssem_stored_program_core_unit.sv
module tb_ssem_stored_program_core_unit;

   // The package names three request codes. The fourth code is unused and
   // must leave the machine untouched while still answering with one beat.
   localparam logic [ssem_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

   // Only the first mismatches are printed; every one is counted.
   localparam int PRINT_LIMIT = 40;

   // Cycles allowed for outstanding responses to drain before giving up.
   localparam int DRAIN_LIMIT = 5000;

   // One response beat as the core should present it.
   typedef struct {
      logic [ssem_pkg::WORD_W-1:0] read_word;
      logic [ssem_pkg::WORD_W-1:0] accumulator;
      logic [ssem_pkg::WORD_W-1:0] counter;
      logic [ssem_pkg::WORD_W-1:0] fetched;
      logic                        halted;
   } core_view_type;

   // Every input of the core holds a known value from time zero.
   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic [ssem_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [ssem_pkg::FUNC_W-1:0]     req_tuser  = ssem_pkg::FUNC_STEP;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [ssem_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;

   // Our own copy of the machine: store, accumulator, control counter,
   // present instruction and halt flag, advanced once per accepted beat.
   logic [ssem_pkg::WORD_W-1:0] store_model [ssem_pkg::STORE_LINES];
   logic [ssem_pkg::WORD_W-1:0] acc_model;
   logic [ssem_pkg::WORD_W-1:0] ctr_model;
   logic [ssem_pkg::WORD_W-1:0] pir_model;
   logic                        halted_model;

   // Responses still owed by the core, oldest first.
   core_view_type expected_views [$];

   int unsigned error_count = 0;

   // Traffic shaping. The sender runs in bursts separated by gaps; the
   // receiver alternates ready and stall runs of random length. Either one
   // can be switched to a steady stream for a stretch.
   bit          tx_bursts  = 1'b0;
   bit          rx_stalls  = 1'b0;
   int unsigned burst_left = 0;
   int unsigned stall_run  = 0;

   ssem_stored_program_core_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #5 clock = ~clock;

   // Hard stop in case the core hangs on a handshake.
   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

   // Receiver back-pressure. When a run ends, the ready line flips and a new
   // random run length is drawn, one range for stalls and another for ready runs.
   always @(posedge clock) begin
      if (!rx_stalls) begin
         rsp_tready <= 1'b1;
         stall_run  <= 0;
      end else if (stall_run == 0) begin
         rsp_tready <= ~rsp_tready;
         stall_run  <= rsp_tready ? $urandom_range(1, 6) : $urandom_range(0, 9);
      end else begin
         stall_run <= stall_run - 1;
      end
   end

   task automatic report_mismatch(input string what,
                                  input logic [ssem_pkg::WORD_W-1:0] got,
                                  input logic [ssem_pkg::WORD_W-1:0] want);
      if (error_count < PRINT_LIMIT)
         $display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   task automatic check_field(input string what,
                              input logic [ssem_pkg::WORD_W-1:0] got,
                              input logic [ssem_pkg::WORD_W-1:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // Build an instruction word. The bits outside the line and function fields
   // are ignored by the decoder, so they are filled at random.
   function automatic logic [ssem_pkg::WORD_W-1:0] make_instr(
      input logic [ssem_pkg::OPC_W-1:0]  opc,
      input logic [ssem_pkg::LINE_W-1:0] addr
   );
      logic [ssem_pkg::WORD_W-1:0] word;
      word = $urandom;
      word[ssem_pkg::LINE_W-1:0] = addr;
      word[ssem_pkg::OPC_LSB +: ssem_pkg::OPC_W] = opc;
      return word;
   endfunction

   // Advance our copy of the machine by one command and return the response
   // that the core must give for it.
   function automatic core_view_type apply_command(
      input logic [ssem_pkg::FUNC_W-1:0] func,
      input logic [ssem_pkg::LINE_W-1:0] addr,
      input logic [ssem_pkg::WORD_W-1:0] word
   );
      core_view_type               view;
      logic [ssem_pkg::WORD_W-1:0] operand;
      view.read_word = '0;
      case (func)
         ssem_pkg::FUNC_STEP: begin
            // A halted machine ignores steps entirely.
            if (!halted_model) begin
               ctr_model = ctr_model + 1;
               // Only the low five bits of the counter address the store.
               pir_model = store_model[ctr_model[ssem_pkg::LINE_W-1:0]];
               operand   = store_model[pir_model[ssem_pkg::LINE_W-1:0]];
               case (pir_model[ssem_pkg::OPC_LSB +: ssem_pkg::OPC_W])
                  ssem_pkg::OPC_JMP: ctr_model = operand;
                  ssem_pkg::OPC_JRP: ctr_model = ctr_model + operand;
                  ssem_pkg::OPC_LDN: acc_model = -operand;
                  ssem_pkg::OPC_STO: store_model[pir_model[ssem_pkg::LINE_W-1:0]] = acc_model;
                  ssem_pkg::OPC_SUB_A, ssem_pkg::OPC_SUB_B: acc_model = acc_model - operand;
                  ssem_pkg::OPC_CMP: begin
                     // Skip the next instruction when the accumulator is negative.
                     if (acc_model[ssem_pkg::WORD_W-1])
                        ctr_model = ctr_model + 1;
                  end
                  ssem_pkg::OPC_STP: halted_model = 1'b1;
               endcase
            end
         end
         ssem_pkg::FUNC_WRITE: store_model[addr] = word;
         ssem_pkg::FUNC_READ:  view.read_word = store_model[addr];
         default: ;
      endcase
      view.accumulator = acc_model;
      view.counter     = ctr_model;
      view.fetched     = pir_model;
      view.halted      = halted_model;
      return view;
   endfunction

   // Present one command beat and hold it until the core takes it. Readiness
   // is looked at right after the edge, so it is the value the core saw.
   // Once taken, the expected response is queued and, when bursting, a gap
   // may follow before the next beat.
   task automatic send_beat(input logic [ssem_pkg::FUNC_W-1:0] func,
                            input logic [ssem_pkg::LINE_W-1:0] addr,
                            input logic [ssem_pkg::WORD_W-1:0] word);
      req_tuser  <= func;
      req_tdata  <= {{ssem_pkg::REQ_PAD_W{1'b0}}, word, addr};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      expected_views.push_back(apply_command(func, addr, word));
      if (tx_bursts) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 10);
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   // Stop sending and wait until every owed response has come back. The
   // first edge is always waited so that valid is never dropped and raised
   // again in the same time step.
   task automatic wait_for_responses();
      int unsigned waited;
      waited = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_views.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // Response checker: each beat the receiver takes is compared field by
   // field with the oldest expectation.
   always @(posedge clock) begin : check_response
      core_view_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_views.size() == 0) begin
            report_mismatch("response beat with no command waiting", rsp_tdata[31:0], '0);
         end else begin
            want = expected_views.pop_front();
            check_field("read_word", rsp_tdata[31:0], want.read_word);
            check_field("accumulator_value", rsp_tdata[63:32], want.accumulator);
            check_field("counter_value", rsp_tdata[95:64], want.counter);
            check_field("fetched_word", rsp_tdata[127:96], want.fetched);
            check_field("is_halted", {31'b0, rsp_tdata[128]}, {31'b0, want.halted});
         end
      end
   end

   // Store writes and reads at the edges of the address and data ranges, a
   // read of a line that only reset has touched, and the unused command code.
   task automatic test_store_extremes();
      tx_bursts = 1'b1;
      rx_stalls = 1'b1;
      send_beat(ssem_pkg::FUNC_WRITE, 5'd31, 32'hFFFF_FFFF);
      send_beat(ssem_pkg::FUNC_READ, 5'd31, 32'h0000_0000);
      send_beat(ssem_pkg::FUNC_READ, 5'd14, 32'hFFFF_FFFF);
      send_beat(FUNC_SPARE, 5'd31, 32'hFFFF_FFFF);
      send_beat(ssem_pkg::FUNC_WRITE, 5'd0, 32'h0000_0000);
   endtask

   // A short program that runs every instruction but the stop. It negates the most
   // negative word, lets subtraction overflow both ways, takes and skips a
   // compare, stores, jumps relative, and jumps to the all-ones counter so
   // that the next step wraps the counter to zero and fetches line zero.
   task automatic test_each_instruction();
      send_beat(ssem_pkg::FUNC_WRITE, 5'd20, 32'h8000_0000);
      send_beat(ssem_pkg::FUNC_WRITE, 5'd21, 32'h0000_0001);
      send_beat(ssem_pkg::FUNC_WRITE, 5'd22, 32'hFFFF_FFFF);
      send_beat(ssem_pkg::FUNC_WRITE, 5'd25, 32'd10);
      send_beat(ssem_pkg::FUNC_WRITE, 5'd0, make_instr(ssem_pkg::OPC_JMP, 5'd25));
      send_beat(ssem_pkg::FUNC_WRITE, 5'd1, make_instr(ssem_pkg::OPC_LDN, 5'd20));
      send_beat(ssem_pkg::FUNC_WRITE, 5'd2, make_instr(ssem_pkg::OPC_SUB_A, 5'd21));
      send_beat(ssem_pkg::FUNC_WRITE, 5'd3, make_instr(ssem_pkg::OPC_CMP, 5'($urandom)));
      send_beat(ssem_pkg::FUNC_WRITE, 5'd4, make_instr(ssem_pkg::OPC_SUB_B, 5'd22));
      send_beat(ssem_pkg::FUNC_WRITE, 5'd5, make_instr(ssem_pkg::OPC_CMP, 5'($urandom)));
      send_beat(ssem_pkg::FUNC_WRITE, 5'd7, make_instr(ssem_pkg::OPC_STO, 5'd24));
      send_beat(ssem_pkg::FUNC_WRITE, 5'd8, make_instr(ssem_pkg::OPC_JRP, 5'd21));
      send_beat(ssem_pkg::FUNC_WRITE, 5'd10, make_instr(ssem_pkg::OPC_JMP, 5'd22));
      repeat (9) send_beat(ssem_pkg::FUNC_STEP, 5'($urandom), $urandom);
      // The store instruction must have left the accumulator in line 24.
      send_beat(ssem_pkg::FUNC_READ, 5'd24, $urandom);
   endtask

   // Random programs. Most beats are steps through whatever the store holds,
   // the rest rewrite lines with instructions or plain data, read lines back,
   // or use the unused code. A stop would freeze the machine for the rest of
   // the run, so before each step the line about to be fetched is patched if
   // it holds a stop. The phase ends by draining every owed response.
   task automatic test_random_programs(input bit bursts, input bit stalls, input int beats);
      int unsigned                 pick;
      logic [ssem_pkg::LINE_W-1:0] next_addr;
      logic [ssem_pkg::WORD_W-1:0] next_word;
      tx_bursts = bursts;
      rx_stalls = stalls;
      repeat (beats) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            next_addr = ctr_model[ssem_pkg::LINE_W-1:0] + 5'd1;
            next_word = store_model[next_addr];
            if (next_word[ssem_pkg::OPC_LSB +: ssem_pkg::OPC_W] == ssem_pkg::OPC_STP) begin
               next_word[ssem_pkg::OPC_LSB +: ssem_pkg::OPC_W] = 3'($urandom_range(0, 6));
               send_beat(ssem_pkg::FUNC_WRITE, next_addr, next_word);
            end
            send_beat(ssem_pkg::FUNC_STEP, 5'($urandom), $urandom);
         end else if (pick < 80) begin
            if ($urandom_range(0, 1))
               send_beat(ssem_pkg::FUNC_WRITE, 5'($urandom),
                         make_instr(3'($urandom), 5'($urandom)));
            else
               send_beat(ssem_pkg::FUNC_WRITE, 5'($urandom), $urandom);
         end else if (pick < 95) begin
            send_beat(ssem_pkg::FUNC_READ, 5'($urandom), $urandom);
         end else begin
            send_beat(FUNC_SPARE, 5'($urandom), $urandom);
         end
      end
      wait_for_responses();
   endtask

   // Plant a stop at the next fetch, run it, then check that further steps
   // change nothing while writes, reads and the unused code still work.
   task automatic test_halt_behavior();
      logic [ssem_pkg::LINE_W-1:0] scratch;
      tx_bursts = 1'b1;
      rx_stalls = 1'b1;
      scratch   = 5'($urandom);
      send_beat(ssem_pkg::FUNC_WRITE, ctr_model[ssem_pkg::LINE_W-1:0] + 5'd1,
                make_instr(ssem_pkg::OPC_STP, 5'($urandom)));
      send_beat(ssem_pkg::FUNC_STEP, 5'($urandom), $urandom);
      repeat (3) send_beat(ssem_pkg::FUNC_STEP, 5'($urandom), $urandom);
      send_beat(ssem_pkg::FUNC_WRITE, scratch, $urandom);
      send_beat(ssem_pkg::FUNC_READ, scratch, $urandom);
      send_beat(FUNC_SPARE, 5'($urandom), $urandom);
      send_beat(ssem_pkg::FUNC_STEP, 5'($urandom), $urandom);
      wait_for_responses();
   endtask

   initial begin
      for (int i = 0; i < ssem_pkg::STORE_LINES; i++)
         store_model[i] = '0;
      acc_model    = '0;
      ctr_model    = '0;
      pir_model    = '0;
      halted_model = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_store_extremes();
      test_each_instruction();
      // Phases differ only in how the two sides idle: both idling, neither,
      // only the sender, only the receiver.
      test_random_programs(1'b1, 1'b1, 390);
      test_random_programs(1'b0, 1'b0, 390);
      test_random_programs(1'b1, 1'b0, 390);
      test_random_programs(1'b0, 1'b1, 390);
      test_halt_behavior();

      // A few more cycles catch any stray beat after the last response.
      repeat (10) @(posedge clock);
      if (expected_views.size() != 0)
         report_mismatch("responses never delivered", expected_views.size(), '0);

      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
